@@ src/utf8_stream_decoder_unit_macros.svh @@
// assertion macros shared by the decoder modules
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define UTF8SD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define UTF8SD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UTF8SD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define UTF8SD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/utf8sd_pkg.sv @@
package utf8sd_pkg;

    localparam int CP_W       = 21;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CP_W-1:0] REPL_CHAR  = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_STRAY   = 3'd1,
        ERR_LEAD    = 3'd2,
        ERR_MISSING = 3'd3,
        ERR_RANGE   = 3'd4
    } err_kind_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        err_kind_t       error_kind;
        logic            last;
    } result_t;

    // results of one committed byte, count is 0..2
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } res_bundle_t;

endpackage

@@ src/utf8_stream_decoder_unit.sv @@
// utf-8 stream decoder: takes one byte per transfer on s_* (s_tuser high marks end of
// input and flushes any open sequence) and returns unicode code points on m_tdata with
// an error kind on m_tuser, U+FFFD standing in for every malformed or out-of-range
// sequence. the block accepts one byte every cycle while the result queue has room; a
// byte that breaks an open sequence yields the error and, when the byte decoded as a
// fresh lead gives a result of its own, that result too, and m_tlast marks the last
// result of each input byte. a byte is held in the input register, then decoded in one
// pass into a result queue of FIFO_DEPTH entries, and its first result is offered once
// it is written there; input stalls only while the queue has fewer than two free
// entries.
module utf8_stream_decoder_unit
#(
    parameter int FIFO_DEPTH = utf8sd_pkg::FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    input  logic        s_tuser,    // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // code_point[20:0]
    output logic [2:0]  m_tuser,    // error_kind[2:0]
    output logic        m_tlast
);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_eoi_reg;
    logic                    room;
    logic                    commit;
    utf8sd_pkg::res_bundle_t bundle;
    utf8sd_pkg::res_bundle_t push;

    assign commit   = in_valid_reg && room;
    assign s_tready = !in_valid_reg || commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tuser;
        end
    end

    utf8sd_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (commit),
        .data_byte    (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .bundle       (bundle)
    );

    // nothing enters the queue unless the byte is really committed
    always_comb
    begin
        push       = bundle;
        push.count = commit ? bundle.count : 2'd0;
    end

    utf8sd_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/utf8sd_decode.sv @@
`include "utf8_stream_decoder_unit_macros.svh"

module utf8sd_decode
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      commit,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_input,
    output utf8sd_pkg::res_bundle_t   bundle
);

    typedef struct packed {
        logic                       emit;
        logic                       skip;
        logic [utf8sd_pkg::CP_W-1:0] cp;
        utf8sd_pkg::err_kind_t      kind;
        logic [utf8sd_pkg::CP_W-1:0] partial;
        logic [1:0]                 expected;
    } lead_t;

    logic [utf8sd_pkg::CP_W-1:0] partial_reg, partial_next;
    logic [1:0]                  expected_reg, expected_next;
    logic                        skip_reg, skip_next;

    lead_t                       lead;
    logic                        is_cont;
    logic [utf8sd_pkg::CP_W-1:0] value;

    function automatic lead_t start_seq(input logic [7:0] b);
        lead_t l;
        l.emit     = 1'b0;
        l.skip     = 1'b0;
        l.cp       = '0;
        l.kind     = utf8sd_pkg::ERR_NONE;
        l.partial  = '0;
        l.expected = 2'd0;
        if (!b[7])
        begin
            l.emit = 1'b1;
            l.cp   = {14'd0, b[6:0]};
        end
        else if (b[7:6] == 2'b10)
        begin
            l.emit = 1'b1;
            l.skip = 1'b1;
            l.cp   = utf8sd_pkg::REPL_CHAR;
            l.kind = utf8sd_pkg::ERR_STRAY;
        end
        else if (b[7:5] == 3'b110)
        begin
            l.partial  = {16'd0, b[4:0]};
            l.expected = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            l.partial  = {17'd0, b[3:0]};
            l.expected = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            l.partial  = {18'd0, b[2:0]};
            l.expected = 2'd3;
        end
        else
        begin
            l.emit = 1'b1;
            l.cp   = utf8sd_pkg::REPL_CHAR;
            l.kind = utf8sd_pkg::ERR_LEAD;
        end
        return l;
    endfunction

    assign lead    = start_seq(data_byte);
    assign is_cont = (data_byte[7:6] == 2'b10);
    assign value   = {partial_reg[14:0], data_byte[5:0]};

    always_comb
    begin
        partial_next  = partial_reg;
        expected_next = expected_reg;
        skip_next     = skip_reg;
        bundle.count  = 2'd0;
        bundle.first  = '{code_point: utf8sd_pkg::REPL_CHAR,
                          error_kind: utf8sd_pkg::ERR_MISSING, last: 1'b0};
        bundle.second = '{code_point: lead.cp, error_kind: lead.kind, last: 1'b1};

        if (end_of_input)
        begin
            skip_next     = 1'b0;
            partial_next  = '0;
            expected_next = 2'd0;
            if (expected_reg != 2'd0)
            begin
                bundle.count = 2'd1;
            end
        end
        else if (expected_reg != 2'd0)
        begin
            if (is_cont)
            begin
                expected_next = expected_reg - 2'd1;
                partial_next  = value;
                if (expected_reg == 2'd1)
                begin
                    partial_next = '0;
                    bundle.count = 2'd1;
                    if ((value >= utf8sd_pkg::SURR_LO && value <= utf8sd_pkg::SURR_HI)
                        || value > utf8sd_pkg::MAX_SCALAR)
                    begin
                        bundle.first.error_kind = utf8sd_pkg::ERR_RANGE;
                    end
                    else
                    begin
                        bundle.first.code_point = value;
                        bundle.first.error_kind = utf8sd_pkg::ERR_NONE;
                    end
                end
            end
            else
            begin
                // sequence broken: report it, then treat the byte as a new lead
                partial_next  = lead.partial;
                expected_next = lead.expected;
                skip_next     = lead.skip;
                bundle.count  = lead.emit ? 2'd2 : 2'd1;
            end
        end
        else if (!(skip_reg && is_cont))
        begin
            partial_next            = lead.partial;
            expected_next           = lead.expected;
            skip_next               = lead.skip;
            bundle.count            = {1'b0, lead.emit};
            bundle.first.code_point = lead.cp;
            bundle.first.error_kind = lead.kind;
        end

        bundle.first.last = (bundle.count == 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= '0;
            expected_reg <= 2'd0;
            skip_reg     <= 1'b0;
        end
        else if (commit)
        begin
            partial_reg  <= partial_next;
            expected_reg <= expected_next;
            skip_reg     <= skip_next;
        end
    end

    `UTF8SD_ASSERT_IMP(a_partial_idle, clk, rst_n, expected_reg == 2'd0, partial_reg == '0, "partial value left over with no open sequence")
    `UTF8SD_ASSERT_IMP(a_skip_idle, clk, rst_n, skip_reg, expected_reg == 2'd0, "skip flag set inside an open sequence")
    `UTF8SD_ASSERT_IMP(a_two_missing, clk, rst_n, bundle.count == 2'd2, bundle.first.error_kind == utf8sd_pkg::ERR_MISSING, "second result without a missing continuation")

endmodule

@@ src/utf8sd_out_fifo.sv @@
`include "utf8_stream_decoder_unit_macros.svh"

module utf8sd_out_fifo
#(
    parameter int DEPTH = utf8sd_pkg::FIFO_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8sd_pkg::res_bundle_t push,
    output logic                    room,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,   // code_point[20:0]
    output logic [2:0]              m_tuser,   // error_kind[2:0]
    output logic                    m_tlast
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8sd_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_alt;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop        = m_tvalid && m_tready;
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_alt = bump(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_alt;
            2'd2:    wr_ptr_next = bump(wr_ptr_alt);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_alt] <= push.second;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {3'd0, mem[rd_ptr_reg].code_point};
    assign m_tuser  = mem[rd_ptr_reg].error_kind;
    assign m_tlast  = mem[rd_ptr_reg].last;

    `UTF8SD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "result queue overfilled")
    `UTF8SD_ASSERT_IMP(a_push_room, clk, rst_n, push.count != 2'd0, room, "results pushed without two free slots")
    `UTF8SD_ASSERT_NXT(a_pop_drain, clk, rst_n, pop && push.count == 2'd0, count_reg == $past(count_reg) - CNT_W'(1), "transfer out did not drain the queue")

endmodule

@@ tb/tb_utf8_stream_decoder_unit.sv @@
module tb_utf8_stream_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PREDICT     = -1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 340;

    typedef struct {
        logic [7:0]                  b;
        logic                        eoi;
        int                          n;
        logic [utf8sd_pkg::CP_W-1:0] cp;
        utf8sd_pkg::err_kind_t       kind;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // decoder state mirrored from the stream so far
    logic [utf8sd_pkg::CP_W-1:0] acc_bits;
    logic [1:0]                  conts_due;
    logic                        skip_conts;

    utf8sd_pkg::result_t step_res [2];
    int                  step_n;
    utf8sd_pkg::result_t pending_points [$];
    utf8sd_pkg::result_t head_point;
    logic [8:0]          burst [$];
    dir_row_t            dir_rows [$];

    // typed expectation of the transfer on offer, PREDICT when the predictor decides
    int                          cur_n;
    logic [utf8sd_pkg::CP_W-1:0] cur_cp;
    utf8sd_pkg::err_kind_t       cur_kind;

    int idle_pct;
    int stall_pct;
    int err_count;
    int cycle_cnt;

    utf8_stream_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void add_point(input logic [utf8sd_pkg::CP_W-1:0] cp,
                                      input utf8sd_pkg::err_kind_t kind);
        step_res[step_n] = '{code_point: cp, error_kind: kind, last: 1'b0};
        step_n++;
    endfunction

    function automatic void open_lead(input logic [7:0] b);
        skip_conts = 1'b0;
        casez (b)
            8'b0???????:
                add_point({14'd0, b[6:0]}, utf8sd_pkg::ERR_NONE);
            8'b10??????:
            begin
                skip_conts = 1'b1;
                add_point(utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_STRAY);
            end
            8'b110?????:
            begin
                acc_bits  = {16'd0, b[4:0]};
                conts_due = 2'd1;
            end
            8'b1110????:
            begin
                acc_bits  = {17'd0, b[3:0]};
                conts_due = 2'd2;
            end
            8'b11110???:
            begin
                acc_bits  = {18'd0, b[2:0]};
                conts_due = 2'd3;
            end
            default:
                add_point(utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_LEAD);
        endcase
    endfunction

    function automatic void decode_step(input logic [7:0] b, input logic eoi);
        step_n = 0;
        if (eoi)
        begin
            skip_conts = 1'b0;
            if (conts_due != 2'd0)
                add_point(utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_MISSING);
            acc_bits  = '0;
            conts_due = 2'd0;
        end
        else if (conts_due != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                acc_bits  = {acc_bits[utf8sd_pkg::CP_W-7:0], b[5:0]};
                conts_due = conts_due - 2'd1;
                if (conts_due == 2'd0)
                begin
                    if ((acc_bits >= utf8sd_pkg::SURR_LO && acc_bits <= utf8sd_pkg::SURR_HI)
                        || acc_bits > utf8sd_pkg::MAX_SCALAR)
                        add_point(utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_RANGE);
                    else
                        add_point(acc_bits, utf8sd_pkg::ERR_NONE);
                    acc_bits = '0;
                end
            end
            else
            begin
                // broken sequence: report it, then take the byte as a new lead
                add_point(utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_MISSING);
                acc_bits  = '0;
                conts_due = 2'd0;
                open_lead(b);
            end
        end
        else if (!(skip_conts && b[7:6] == 2'b10))
            open_lead(b);
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_step(s_tdata, s_tuser);
                if (cur_n == PREDICT)
                begin
                    for (int i = 0; i < step_n; i++)
                        pending_points.push_back(step_res[i]);
                end
                else if (cur_n == 1)
                    pending_points.push_back('{code_point: cur_cp, error_kind: cur_kind,
                                               last: 1'b1});
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_points.size() == 0)
                    flag_mismatch("unexpected result", {8'd0, m_tdata}, 32'd0);
                else
                begin
                    head_point = pending_points.pop_front();
                    if (m_tdata[utf8sd_pkg::CP_W-1:0] !== head_point.code_point)
                        flag_mismatch("code_point", 32'(m_tdata[utf8sd_pkg::CP_W-1:0]),
                                      32'(head_point.code_point));
                    if (m_tuser !== head_point.error_kind)
                        flag_mismatch("error_kind", 32'(m_tuser),
                                      32'(head_point.error_kind));
                    if (m_tlast !== head_point.last)
                        flag_mismatch("tlast", 32'(m_tlast), 32'(head_point.last));
                end
            end
        end
    end

    // called and left at a falling edge; valid stays high from one transfer to the next unless an idle gap is drawn
    task automatic send_item(input logic [7:0] b, input logic eoi, input int n,
                             input logic [utf8sd_pkg::CP_W-1:0] cp,
                             input utf8sd_pkg::err_kind_t kind);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        cur_n    = n;
        cur_cp   = cp;
        cur_kind = kind;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eoi;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain_points;
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic add_row(input logic [7:0] b, input logic eoi, input int n,
                           input logic [utf8sd_pkg::CP_W-1:0] cp,
                           input utf8sd_pkg::err_kind_t kind);
        dir_rows.push_back('{b: b, eoi: eoi, n: n, cp: cp, kind: kind});
    endtask

    task automatic push_conts(input int cnt);
        logic [31:0] rnd;
        for (int i = 0; i < cnt; i++)
        begin
            rnd = $urandom;
            burst.push_back({1'b0, 2'b10, rnd[5:0]});
        end
    endtask

    // one code point's worth of bytes, mostly well formed
    task automatic build_burst;
        int          sel;
        int          len;
        logic [31:0] rnd;
        logic [7:0]  lead;
        sel = $urandom_range(99);
        rnd = $urandom;
        len = $urandom_range(1, 4);
        if (sel >= 78 && sel < 84 && len == 1)
            len = 2;
        case (len)
            1: lead = {1'b0, rnd[6:0]};
            2: lead = {3'b110, rnd[4:0]};
            3: lead = (rnd[10:8] == 3'd0) ? 8'hED : {4'b1110, rnd[3:0]};
            default: lead = (rnd[10:9] == 2'd0) ? 8'hF4 : {5'b11110, rnd[2:0]};
        endcase
        if (sel < 78)
        begin
            burst.push_back({1'b0, lead});
            push_conts(len - 1);
        end
        else if (sel < 84)
        begin
            // sequence cut short, the next burst's bytes decide how it ends
            burst.push_back({1'b0, lead});
            push_conts($urandom_range(0, len - 2));
        end
        else if (sel < 89)
            push_conts($urandom_range(1, 4));
        else if (sel < 93)
            burst.push_back({1'b1, rnd[7:0]});
        else if (sel < 96)
            burst.push_back({1'b0, 5'b11111, rnd[2:0]});
        else
            burst.push_back({1'b0, rnd[7:0]});
    endtask

    task automatic run_phase(input int snd_idle, input int rcv_stall, input int n_items);
        int         sent;
        logic [8:0] it;
        idle_pct  = snd_idle;
        stall_pct = rcv_stall;
        sent      = 0;
        while (sent < n_items)
        begin
            build_burst();
            while (burst.size() != 0)
            begin
                it = burst.pop_front();
                send_item(it[7:0], it[8], PREDICT, '0, utf8sd_pkg::ERR_NONE);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        s_tuser    = 1'b0;
        acc_bits   = '0;
        conts_due  = 2'd0;
        skip_conts = 1'b0;
        cur_n      = PREDICT;
        cur_cp     = '0;
        cur_kind   = utf8sd_pkg::ERR_NONE;
        idle_pct   = 0;
        stall_pct  = 0;
        err_count  = 0;
        cycle_cnt  = 0;

        add_row(8'h00, 1'b0, 1, 21'h000000, utf8sd_pkg::ERR_NONE);
        add_row(8'h7F, 1'b0, 1, 21'h00007F, utf8sd_pkg::ERR_NONE);
        add_row(8'h80, 1'b0, 1, utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_STRAY);
        add_row(8'hBF, 1'b0, 0, '0, utf8sd_pkg::ERR_NONE);       // swallowed after a stray byte
        add_row(8'h41, 1'b0, 1, 21'h000041, utf8sd_pkg::ERR_NONE);
        add_row(8'hF8, 1'b0, 1, utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_LEAD);
        add_row(8'hFF, 1'b0, 1, utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_LEAD);
        add_row(8'hC2, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'hA9, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'hED, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE); // surrogate
        add_row(8'hA0, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'h80, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'hC3, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE); // broken by a plain byte
        add_row(8'h41, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'hE1, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'h80, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'hA5, 1'b1, 1, utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_MISSING);
        add_row(8'h00, 1'b1, 0, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'h80, 1'b0, 1, utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_STRAY);
        add_row(8'hFF, 1'b1, 0, '0, utf8sd_pkg::ERR_NONE);       // end of input clears the skip
        add_row(8'h80, 1'b0, 1, utf8sd_pkg::REPL_CHAR, utf8sd_pkg::ERR_STRAY);
        add_row(8'hF7, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE); // largest four byte value
        add_row(8'hBF, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'hBF, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);
        add_row(8'hBF, 1'b0, PREDICT, '0, utf8sd_pkg::ERR_NONE);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].b, dir_rows[i].eoi, dir_rows[i].n, dir_rows[i].cp,
                      dir_rows[i].kind);
        drain_points();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(88, 0, PHASE_ITEMS);
        drain_points();
        run_phase(0, 88, PHASE_ITEMS);
        run_phase(16, 16, PHASE_ITEMS);
        drain_points();

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/utf8sd_pkg.sv
src/utf8sd_decode.sv
src/utf8sd_out_fifo.sv
src/utf8_stream_decoder_unit.sv
tb/tb_utf8_stream_decoder_unit.sv
